// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the block buffer handoff manager RTL.
// No dependencies; the check bodies are left out when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property check on the rising clock edge, off while reset is held.
`define BBHM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Condition that must never be true on a rising clock edge outside reset.
`define BBHM_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define BBHM_ASSERT(lbl, prop, msg)
`define BBHM_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

// File: hw/rtl/bbhm_pkg.sv
// Package for the block buffer handoff manager: field widths, action and
// register codes, controller states and the controller command struct. No dependencies.
package bbhm_pkg;

  // Fixed field widths.
  localparam int unsigned ActionW  = 2;
  localparam int unsigned FrameW   = 13;
  localparam int unsigned EpfW     = 6;
  localparam int unsigned AttrW    = 64;
  localparam int unsigned OffsetW  = 18;
  localparam int unsigned CapW     = 17;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 13;

  // Configuration reset values.
  localparam logic [FrameW-1:0] FpbReset = 13'd256;
  localparam logic [EpfW-1:0]   EpfReset = 6'd2;

  // Actions carried by an input item.
  typedef enum logic [ActionW-1:0] {
    ACT_ACQ_WR     = 2'd0,
    ACT_ACQ_RD     = 2'd1,
    ACT_COMMIT_WR  = 2'd2,
    ACT_CONSUME_RD = 2'd3
  } action_e;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_FRAMES_PER_BLOCK   = 1'd0,
    CFG_ELEMENTS_PER_FRAME = 1'd1
  } cfg_idx_e;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_FETCH = 2'd1,
    ST_CALC  = 2'd2,
    ST_EMIT  = 2'd3
  } ctrl_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic fetch;
    logic calc;
    logic emit;
  } ctrl_cmd_t;

endpackage

// File: hw/rtl/block_buffer_handoff_manager.sv
// Block buffer handoff manager, top level. Depends on bbhm_pkg, bbhm_ctrl, bbhm_datapath.
// Each item passes the fetch and calc states, the fetch-then-update sequence on the
// block state RAMs, and then emit, where its result is loaded into the output register;
// no new item is taken before that. A result still waiting at the output holds the next
// item in its last step, so the input is not taken again until that result has moved
// on. Reset (asynchronous, active low) clears control, indexes, grants and attribute
// flags and frees every block; with no clearing pass, items are taken right after reset.
module block_buffer_handoff_manager #(
  parameter int unsigned NUM_BLOCKS = 8,
  parameter int unsigned MAX_FRAMES = 4096,
  localparam int unsigned IdxW = $clog2(NUM_BLOCKS)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration write port.
  input  logic                          cfg_we_i,
  input  logic [bbhm_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [bbhm_pkg::CfgDataW-1:0] cfg_wdata_i,
  // Input channel.
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [bbhm_pkg::ActionW-1:0]  action_i,
  input  logic [bbhm_pkg::FrameW-1:0]   frame_count_i,
  input  logic [bbhm_pkg::AttrW-1:0]    attribute_in_i,
  input  logic                          attribute_present_i,
  // Output channel.
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          granted_o,
  output logic [IdxW-1:0]               block_index_o,
  output logic [bbhm_pkg::OffsetW-1:0]  element_offset_o,
  output logic [bbhm_pkg::FrameW-1:0]   frames_avail_o,
  output logic [bbhm_pkg::AttrW-1:0]    attribute_out_o,
  output logic                          block_released_o
);
  import bbhm_pkg::*;

  ctrl_cmd_t cmd;

  // Sequencing of each item.
  bbhm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  // Block state and result computation.
  bbhm_datapath #(
    .NUM_BLOCKS (NUM_BLOCKS),
    .MAX_FRAMES (MAX_FRAMES)
  ) u_datapath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .cfg_we_i            (cfg_we_i),
    .cfg_index_i         (cfg_index_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .action_i            (action_i),
    .frame_count_i       (frame_count_i),
    .attribute_in_i      (attribute_in_i),
    .attribute_present_i (attribute_present_i),
    .granted_o           (granted_o),
    .block_index_o       (block_index_o),
    .element_offset_o    (element_offset_o),
    .frames_avail_o      (frames_avail_o),
    .attribute_out_o     (attribute_out_o),
    .block_released_o    (block_released_o)
  );

endmodule

// File: hw/rtl/bbhm_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module bbhm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 8,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/bbhm_ctrl.sv
// Controller state machine of the block buffer handoff manager.
// Depends on bbhm_pkg and assert_macros.svh.
`include "assert_macros.svh"

module bbhm_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output bbhm_pkg::ctrl_cmd_t  cmd_o
);
  import bbhm_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;

  // State and output-valid registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_FETCH;
        end
      end
      ST_FETCH: begin
        cmd_o.fetch = 1'b1;
        state_d     = ST_CALC;
      end
      ST_CALC: begin
        cmd_o.calc = 1'b1;
        state_d    = ST_EMIT;
      end
      ST_EMIT: begin
        // The result register may still hold an earlier result.
        if (!out_valid_q || out_ready_i) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // The output register is full from a load until its transfer.
  always_comb begin
    if (cmd_o.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  `BBHM_ASSERT(a_valid_from_emit, $rose(out_valid_q) |-> $past(state_q == ST_EMIT), "result appeared without a load")
  `BBHM_ASSERT(a_stall_holds, (state_q == ST_EMIT) && out_valid_q && !out_ready_i |=> (state_q == ST_EMIT) && out_valid_q, "stalled result was overwritten")
  `BBHM_ASSERT(a_accept_starts, in_valid_i && (state_q == ST_IDLE) |=> (state_q == ST_FETCH), "accepted transfer did not start work")

endmodule

// File: hw/rtl/bbhm_datapath.sv
// Datapath of the block buffer handoff manager: configuration, ring indexes,
// grants, per-block flags, block state RAMs and result registers.
// Depends on bbhm_pkg, bbhm_ram and assert_macros.svh.
`include "assert_macros.svh"

module bbhm_datapath #(
  parameter int unsigned NUM_BLOCKS = 8,
  parameter int unsigned MAX_FRAMES = 4096,
  localparam int unsigned IdxW = $clog2(NUM_BLOCKS)
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  bbhm_pkg::ctrl_cmd_t                cmd_i,
  input  logic                               cfg_we_i,
  input  logic [bbhm_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [bbhm_pkg::CfgDataW-1:0]      cfg_wdata_i,
  input  logic [bbhm_pkg::ActionW-1:0]       action_i,
  input  logic [bbhm_pkg::FrameW-1:0]        frame_count_i,
  input  logic [bbhm_pkg::AttrW-1:0]         attribute_in_i,
  input  logic                               attribute_present_i,
  output logic                               granted_o,
  output logic [IdxW-1:0]                    block_index_o,
  output logic [bbhm_pkg::OffsetW-1:0]       element_offset_o,
  output logic [bbhm_pkg::FrameW-1:0]        frames_avail_o,
  output logic [bbhm_pkg::AttrW-1:0]         attribute_out_o,
  output logic                               block_released_o
);
  import bbhm_pkg::*;

  localparam int unsigned PosW  = 2 * FrameW;
  localparam int unsigned ProdW = FrameW + EpfW;
  localparam logic [CapW-1:0] MaxFrames = CapW'(MAX_FRAMES);
  localparam logic [IdxW:0]   NumBlk    = (IdxW + 1)'(NUM_BLOCKS);

  function automatic logic [IdxW-1:0] next_idx(input logic [IdxW-1:0] idx);
    logic [IdxW:0] inc;
    inc = {1'b0, idx} + 1'b1;
    return (inc >= NumBlk) ? '0 : inc[IdxW-1:0];
  endfunction

  // Configuration registers.
  logic [FrameW-1:0] fpb_q;
  logic [EpfW-1:0]   epf_q;

  // Ring state.
  logic [IdxW-1:0]       wr_idx_q, wr_idx_d, rd_idx_q, rd_idx_d;
  logic                  wgrant_q, wgrant_d, rgrant_q, rgrant_d;
  logic [NUM_BLOCKS-1:0] free_q, free_d, attr_vld_q, attr_vld_d;

  // Captured item.
  action_e         act_q;
  logic [FrameW-1:0] count_q;
  logic [AttrW-1:0]  attr_in_q;
  logic              attr_pres_q;
  logic [IdxW-1:0]   blk_q;

  // Intermediate result.
  logic              res_grant_q, res_rel_q;
  logic [FrameW-1:0] res_pos_q, res_avail_q;
  logic [AttrW-1:0]  res_attr_q;
  logic              r_grant, r_rel;
  logic [FrameW-1:0] r_pos, r_avail;
  logic [AttrW-1:0]  r_attr;

  // RAM ports.
  logic             pos_we, attr_we;
  logic [PosW-1:0]  pos_wdata, pos_rdata;
  logic [AttrW-1:0] attr_rdata;

  // Working values.
  logic [CapW-1:0]   fpb_ext, cap_ext;
  logic [FrameW-1:0] cap, fill_r, read_r, left, take, new_read, fill_clamp;
  logic              drained;
  logic [EpfW-1:0]   epf_eff;
  logic [ProdW-1:0]  prod;
  action_e           act_in;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fpb_q <= FpbReset;
      epf_q <= EpfReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_FRAMES_PER_BLOCK:   fpb_q <= cfg_wdata_i[FrameW-1:0];
        CFG_ELEMENTS_PER_FRAME: epf_q <= cfg_wdata_i[EpfW-1:0];
        default: ;
      endcase
    end
  end

  // Item capture; write actions address the write index, read actions the read index.
  assign act_in = action_e'(action_i);
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      act_q       <= act_in;
      count_q     <= frame_count_i;
      attr_in_q   <= attribute_in_i;
      attr_pres_q <= attribute_present_i;
      blk_q       <= ((act_in == ACT_ACQ_WR) || (act_in == ACT_COMMIT_WR)) ? wr_idx_q
                                                                            : rd_idx_q;
    end
  end

  // Block state RAMs: fill and read position together, and the attribute.
  bbhm_ram #(
    .Width (PosW),
    .Depth (NUM_BLOCKS)
  ) u_pos_ram (
    .clk_i   (clk_i),
    .we_i    (pos_we),
    .waddr_i (blk_q),
    .wdata_i (pos_wdata),
    .re_i    (cmd_i.fetch),
    .raddr_i (blk_q),
    .rdata_o (pos_rdata)
  );

  bbhm_ram #(
    .Width (AttrW),
    .Depth (NUM_BLOCKS)
  ) u_attr_ram (
    .clk_i   (clk_i),
    .we_i    (attr_we),
    .waddr_i (blk_q),
    .wdata_i (attr_in_q),
    .re_i    (cmd_i.fetch),
    .raddr_i (blk_q),
    .rdata_o (attr_rdata)
  );

  // Capacity clamped to 1..MAX_FRAMES.
  assign fpb_ext = CapW'(fpb_q);
  assign cap_ext = (fpb_q == '0) ? CapW'(1) : ((fpb_ext > MaxFrames) ? MaxFrames : fpb_ext);
  assign cap     = cap_ext[FrameW-1:0];

  // Commit and consume arithmetic on the fetched entry.
  assign fill_r     = pos_rdata[PosW-1:FrameW];
  assign read_r     = pos_rdata[FrameW-1:0];
  assign left       = fill_r - read_r;
  assign drained    = (count_q >= left);
  assign take       = drained ? left : count_q;
  assign new_read   = read_r + take;
  assign fill_clamp = (count_q > cap) ? cap : count_q;

  // Action decode and state update.
  always_comb begin
    wr_idx_d   = wr_idx_q;
    rd_idx_d   = rd_idx_q;
    wgrant_d   = wgrant_q;
    rgrant_d   = rgrant_q;
    free_d     = free_q;
    attr_vld_d = attr_vld_q;
    pos_we     = 1'b0;
    pos_wdata  = {fill_clamp, {FrameW{1'b0}}};
    attr_we    = 1'b0;
    r_grant    = 1'b0;
    r_rel      = 1'b0;
    r_pos      = '0;
    r_avail    = '0;
    r_attr     = '0;
    if (cmd_i.calc) begin
      unique case (act_q)
        ACT_ACQ_WR: begin
          wgrant_d = free_q[blk_q];
          if (free_q[blk_q]) begin
            r_grant = 1'b1;
            r_avail = cap;
          end
        end
        ACT_ACQ_RD: begin
          rgrant_d = !free_q[blk_q];
          if (!free_q[blk_q]) begin
            r_grant = 1'b1;
            r_pos   = read_r;
            r_avail = left;
          end
        end
        ACT_COMMIT_WR: begin
          if (wgrant_q && (count_q != '0)) begin
            pos_we        = 1'b1;
            free_d[blk_q] = 1'b0;
            if (attr_pres_q) begin
              attr_we           = 1'b1;
              attr_vld_d[blk_q] = 1'b1;
            end
            wgrant_d = 1'b0;
            wr_idx_d = next_idx(blk_q);
            r_grant  = 1'b1;
            r_avail  = fill_clamp;
          end
        end
        ACT_CONSUME_RD: begin
          if (rgrant_q) begin
            r_grant = 1'b1;
            r_attr  = attr_vld_q[blk_q] ? attr_rdata : '0;
            if (drained) begin
              // The block is drained: free it and move to the next one.
              free_d[blk_q] = 1'b1;
              rgrant_d      = 1'b0;
              rd_idx_d      = next_idx(blk_q);
              r_rel         = 1'b1;
            end else begin
              pos_we    = 1'b1;
              pos_wdata = {fill_r, new_read};
              r_pos     = new_read;
              r_avail   = left - take;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Ring state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_idx_q   <= '0;
      rd_idx_q   <= '0;
      wgrant_q   <= 1'b0;
      rgrant_q   <= 1'b0;
      free_q     <= '1;
      attr_vld_q <= '0;
    end else begin
      wr_idx_q   <= wr_idx_d;
      rd_idx_q   <= rd_idx_d;
      wgrant_q   <= wgrant_d;
      rgrant_q   <= rgrant_d;
      free_q     <= free_d;
      attr_vld_q <= attr_vld_d;
    end
  end

  // Intermediate result registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.calc) begin
      res_grant_q <= r_grant;
      res_rel_q   <= r_rel;
      res_pos_q   <= r_pos;
      res_avail_q <= r_avail;
      res_attr_q  <= r_attr;
    end
  end

  // Element offset: read position times elements per frame, zero read as one.
  assign epf_eff = (epf_q == '0) ? EpfW'(1) : epf_q;
  assign prod    = ProdW'(res_pos_q) * ProdW'(epf_eff);

  // Output register, held while the result waits for its transfer.
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      granted_o        <= res_grant_q;
      block_index_o    <= blk_q;
      element_offset_o <= prod[OffsetW-1:0];
      frames_avail_o   <= res_avail_q;
      attribute_out_o  <= res_attr_q;
      block_released_o <= res_rel_q;
    end
  end

  `BBHM_ASSERT_NEVER(a_wgrant_on_free, wgrant_q && !free_q[wr_idx_q], "write grant held on a filled block")
  `BBHM_ASSERT_NEVER(a_rgrant_on_filled, rgrant_q && free_q[rd_idx_q], "read grant held on a free block")
  `BBHM_ASSERT(a_release_advances, cmd_i.calc && r_rel |=> (rd_idx_q != $past(rd_idx_q)) && !rgrant_q, "release did not advance the read index")

endmodule
